/* hdl/skac_pkg.sv */
`default_nettype none

package skac_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_NORM,
    ST_LOG_MUL,
    ST_LOG_SUM,
    ST_DB_MUL,
    ST_DB,
    ST_CMP,
    ST_RED_HARD,
    ST_SQ1,
    ST_SQ2,
    ST_SQ3,
    ST_DIV,
    ST_GAIN_MUL,
    ST_EXP_IDX,
    ST_EXP_MUL,
    ST_EXP_SUM,
    ST_OUT_A,
    ST_OUT_B,
    ST_OUT_C,
    ST_FINISH
  } skac_state_t;

  localparam logic [2:0] REG_ENABLE    = 3'd0;
  localparam logic [2:0] REG_CHANNELS  = 3'd1;
  localparam logic [2:0] REG_ATTACK    = 3'd2;
  localparam logic [2:0] REG_RELEASE   = 3'd3;
  localparam logic [2:0] REG_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_KNEE      = 3'd5;
  localparam logic [2:0] REG_SLOPE     = 3'd6;
  localparam logic [2:0] REG_MAKEUP    = 3'd7;

  localparam logic [23:0] ENV_EPS   = 24'd8;
  localparam logic [14:0] RED_MAX   = 15'd24576;
  localparam logic [17:0] DB_SCALE  = 18'd24660;
  localparam logic [17:0] EXP_SCALE = 18'd43541;

  function automatic logic [16:0] log2_entry(input logic [4:0] idx);
    logic [16:0] r;
    case (idx)
      5'd0:    r = 17'd0;
      5'd1:    r = 17'd5732;
      5'd2:    r = 17'd11136;
      5'd3:    r = 17'd16248;
      5'd4:    r = 17'd21098;
      5'd5:    r = 17'd25711;
      5'd6:    r = 17'd30109;
      5'd7:    r = 17'd34312;
      5'd8:    r = 17'd38336;
      5'd9:    r = 17'd42196;
      5'd10:   r = 17'd45904;
      5'd11:   r = 17'd49472;
      5'd12:   r = 17'd52911;
      5'd13:   r = 17'd56229;
      5'd14:   r = 17'd59434;
      5'd15:   r = 17'd62534;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  function automatic logic [17:0] exp2_entry(input logic [4:0] idx);
    logic [17:0] r;
    case (idx)
      5'd0:    r = 18'd65536;
      5'd1:    r = 18'd68438;
      5'd2:    r = 18'd71468;
      5'd3:    r = 18'd74632;
      5'd4:    r = 18'd77936;
      5'd5:    r = 18'd81386;
      5'd6:    r = 18'd84990;
      5'd7:    r = 18'd88752;
      5'd8:    r = 18'd92682;
      5'd9:    r = 18'd96785;
      5'd10:   r = 18'd101070;
      5'd11:   r = 18'd105545;
      5'd12:   r = 18'd110218;
      5'd13:   r = 18'd115098;
      5'd14:   r = 18'd120194;
      5'd15:   r = 18'd125515;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/soft_knee_audio_compressor_unit.sv */
`default_nettype none
// Soft-knee feed-forward compressor for stereo Q1.15 frames.
// Input channel: in_valid / in_stall with sample_a, sample_b; a word is taken
// when in_valid is high and in_stall low. in_stall stays high while a frame
// is being worked on, so one frame is in flight at a time.
// Output channel: out_valid / out_stall with out_a, out_b, reduction_db, held
// in an output register; the next frame may be accepted while a result waits.
// A frame runs through one shared 34x18 multiplier under a sequencer; when
// compressing, the time from accept to accept varies with the leading-one
// normalise loop (one bit a cycle, up to 20 shifts) and, inside the knee
// only, a 25-step restoring divider by the knee width.
// A frame with compression disabled passes through unchanged.
// Registers sit on an APB port, register i at byte address 4*i; write only
// while idle. Reset (rst, synchronous) loads the default register values,
// clears the envelope and empties the output register.
// If the receiver stalls, the result holds and the block stops in its final
// step until the output register is free.
module soft_knee_audio_compressor_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] sample_a,
  input  wire logic signed [15:0] sample_b,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_a,
  output logic signed [15:0]      out_b,
  output logic [14:0]             reduction_db,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import skac_pkg::*;

  skac_state_t state, state_next;

  logic               enable_r;
  logic [1:0]         channels_r;
  logic [15:0]        attack_r;
  logic [15:0]        release_r;
  logic signed [15:0] thr_r;
  logic [12:0]        knee_r;
  logic [15:0]        slope_r;
  logic [12:0]        makeup_r;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  logic [23:0]        env_r;
  logic signed [15:0] a_r, b_r;
  logic               two_r;
  logic [23:0]        lvl_r;
  logic [23:0]        norm_r;
  logic [4:0]         cnt_r;
  logic signed [21:0] lg_r;
  logic signed [17:0] over_r;
  logic [13:0]        q_r;
  logic [24:0]        dq_r;
  logic [12:0]        rem_r;
  logic [14:0]        red_r;
  logic [15:0]        f_r;
  logic signed [7:0]  ip_r;
  logic [31:0]        gain_r;
  logic signed [15:0] res_a, res_b;

  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_p;

  logic               accept_in;
  logic               out_free;
  logic               rise;
  logic               norm_done;
  logic signed [18:0] twice;
  logic signed [18:0] wext;
  logic               knee_zero;
  logic               knee_hard;
  logic [13:0]        rem_sh;
  logic               qbit;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = paddr[4:2];
  assign in_stall  = (state != ST_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign rise      = lvl_r > env_r;
  assign norm_done = norm_r[23] || (cnt_r == 5'd0);
  assign twice     = {over_r, 1'b0};
  assign wext      = $signed({6'b0, knee_r});
  assign knee_zero = twice <= -wext;
  assign knee_hard = twice >= wext;
  assign rem_sh    = {rem_r, dq_r[24]};
  assign qbit      = rem_sh >= {1'b0, knee_r};

  function automatic logic signed [15:0] sat16(input logic signed [51:0] p);
    logic signed [35:0] v;
    logic signed [15:0] r;
    v = p[51:16];
    if (v > 36'sd32767) begin
      r = 16'sd32767;
    end else if (v < -36'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [14:0] sat_red(input logic [24:0] v);
    return (v > {10'b0, RED_MAX}) ? RED_MAX : v[14:0];
  endfunction

  function automatic logic channels_in_two(input logic [1:0] c);
    return c != 2'd1;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable_r   <= 1'b1;
      channels_r <= 2'd2;
      attack_r   <= 16'd65000;
      release_r  <= 16'd65500;
      thr_r      <= -16'sd5120;
      knee_r     <= 13'd1536;
      slope_r    <= 16'd49152;
      makeup_r   <= 13'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ENABLE:    enable_r   <= pwdata[0];
        REG_CHANNELS:  channels_r <= pwdata[1:0];
        REG_ATTACK:    attack_r   <= pwdata[15:0];
        REG_RELEASE:   release_r  <= pwdata[15:0];
        REG_THRESHOLD: thr_r      <= pwdata[15:0];
        REG_KNEE:      knee_r     <= pwdata[12:0];
        REG_SLOPE:     slope_r    <= pwdata[15:0];
        REG_MAKEUP:    makeup_r   <= pwdata[12:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ENABLE:    prdata = {31'b0, enable_r};
      REG_CHANNELS:  prdata = {30'b0, channels_r};
      REG_ATTACK:    prdata = {16'b0, attack_r};
      REG_RELEASE:   prdata = {16'b0, release_r};
      REG_THRESHOLD: prdata = {16'b0, thr_r};
      REG_KNEE:      prdata = {19'b0, knee_r};
      REG_SLOPE:     prdata = {16'b0, slope_r};
      REG_MAKEUP:    prdata = {19'b0, makeup_r};
      default:       prdata = 32'b0;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_ENV_MUL: begin
        mul_a = {10'b0, rise ? (lvl_r - env_r) : (env_r - lvl_r)};
        mul_b = {2'b0, rise ? attack_r : release_r};
      end
      ST_LOG_MUL: begin
        mul_a = {17'b0, log2_entry({1'b0, norm_r[22:19]} + 5'd1)
                        - log2_entry({1'b0, norm_r[22:19]})};
        mul_b = {10'b0, norm_r[18:11]};
      end
      ST_DB_MUL: begin
        mul_a = {{12{lg_r[21]}}, lg_r};
        mul_b = DB_SCALE;
      end
      ST_CMP: begin
        mul_a = {{16{over_r[17]}}, over_r};
        mul_b = {2'b0, slope_r};
      end
      ST_SQ1: begin
        mul_a = {18'b0, slope_r};
        mul_b = {4'b0, q_r};
      end
      ST_SQ2: begin
        mul_a = {4'b0, mul_p[29:0]};
        mul_b = {4'b0, q_r};
      end
      ST_GAIN_MUL: begin
        mul_a = {{18{1'b0}}, 16'({3'b0, makeup_r} - {1'b0, red_r})};
        mul_a = {{18{mul_a[15]}}, mul_a[15:0]};
        mul_b = EXP_SCALE;
      end
      ST_EXP_MUL: begin
        mul_a = {16'b0, exp2_entry({1'b0, f_r[15:12]} + 5'd1)
                        - exp2_entry({1'b0, f_r[15:12]})};
        mul_b = {10'b0, f_r[11:4]};
      end
      ST_OUT_A: begin
        mul_a = {2'b0, gain_r};
        mul_b = {{2{a_r[15]}}, a_r};
      end
      ST_OUT_B: begin
        mul_a = {2'b0, gain_r};
        mul_b = {{2{b_r[15]}}, b_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (accept_in) state_next = enable_r ? ST_ENV_MUL : ST_FINISH;
      ST_ENV_MUL:  state_next = ST_ENV_UPD;
      ST_ENV_UPD:  state_next = ST_NORM;
      ST_NORM:     if (norm_done) state_next = ST_LOG_MUL;
      ST_LOG_MUL:  state_next = ST_LOG_SUM;
      ST_LOG_SUM:  state_next = ST_DB_MUL;
      ST_DB_MUL:   state_next = ST_DB;
      ST_DB:       state_next = ST_CMP;
      ST_CMP: begin
        if (knee_zero) state_next = ST_GAIN_MUL;
        else if (knee_hard) state_next = ST_RED_HARD;
        else state_next = ST_SQ1;
      end
      ST_RED_HARD: state_next = ST_GAIN_MUL;
      ST_SQ1:      state_next = ST_SQ2;
      ST_SQ2:      state_next = ST_SQ3;
      ST_SQ3:      state_next = ST_DIV;
      ST_DIV:      if (cnt_r == 5'd0) state_next = ST_GAIN_MUL;
      ST_GAIN_MUL: state_next = ST_EXP_IDX;
      ST_EXP_IDX:  state_next = ST_EXP_MUL;
      ST_EXP_MUL:  state_next = ST_EXP_SUM;
      ST_EXP_SUM:  state_next = ST_OUT_A;
      ST_OUT_A:    state_next = ST_OUT_B;
      ST_OUT_B:    state_next = ST_OUT_C;
      ST_OUT_C:    state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // envelope: control state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      env_r <= '0;
    end else if (state == ST_ENV_UPD) begin
      env_r <= rise ? (lvl_r - mul_p[39:16]) : (lvl_r + mul_p[39:16]);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    logic [16:0]        abs_a, abs_b;
    logic [17:0]        abs_sum;
    logic [16:0]        mean;
    logic [23:0]        env_new;
    logic signed [5:0]  expo;
    logic signed [51:0] db_sum;
    logic signed [51:0] db_full;
    logic signed [16:0] db17;
    logic [17:0]        mant;
    logic [7:0]         nsh;
    logic [4:0]         psh;
    abs_a   = sample_a[15] ? 17'(-{sample_a[15], sample_a}) : {1'b0, sample_a};
    abs_b   = sample_b[15] ? 17'(-{sample_b[15], sample_b}) : {1'b0, sample_b};
    abs_sum = {1'b0, abs_a} + {1'b0, abs_b};
    mean    = (channels_in_two(channels_r)) ? abs_sum[17:1] : abs_a;
    env_new = rise ? (lvl_r - mul_p[39:16]) : (lvl_r + mul_p[39:16]);
    expo    = $signed({1'b0, cnt_r}) - 6'sd23;
    db_sum  = mul_p + 52'sd524288;
    db_full = db_sum >>> 20;
    db17    = (db_full < -52'sd25600) ? -17'sd25600 : db_full[16:0];
    mant    = exp2_entry({1'b0, f_r[15:12]}) + 18'(mul_p[51:8]);
    nsh     = 8'(-ip_r);
    psh     = (ip_r > 8'sd20) ? 5'd20 : ip_r[4:0];
    case (state)
      ST_IDLE: begin
        if (accept_in) begin
          a_r   <= sample_a;
          b_r   <= sample_b;
          two_r <= channels_in_two(channels_r);
          // the mean never exceeds 2^15, so it fits the Q1.23 level exactly
          lvl_r <= 24'({mean, 8'b0});
          res_a <= sample_a;
          res_b <= sample_b;
          red_r <= '0;
        end
      end
      ST_ENV_UPD: begin
        norm_r <= env_new + ENV_EPS;
        cnt_r  <= 5'd23;
      end
      ST_NORM: begin
        if (!norm_done) begin
          norm_r <= {norm_r[22:0], 1'b0};
          cnt_r  <= cnt_r - 5'd1;
        end
      end
      ST_LOG_SUM: begin
        lg_r <= $signed({expo, 16'b0})
              + $signed({5'b0, log2_entry({1'b0, norm_r[22:19]})})
              + $signed({5'b0, 17'(mul_p[51:8])});
      end
      ST_DB: begin
        over_r <= {db17[16], db17} - {{2{thr_r[15]}}, thr_r};
      end
      ST_CMP: begin
        red_r <= '0;
        q_r   <= 14'(twice + wext);
      end
      ST_RED_HARD: red_r <= sat_red({8'b0, mul_p[32:16]});
      ST_SQ3: begin
        dq_r  <= mul_p[43:19];
        rem_r <= '0;
        cnt_r <= 5'd24;
      end
      ST_DIV: begin
        dq_r  <= {dq_r[23:0], qbit};
        rem_r <= qbit ? 13'(rem_sh - {1'b0, knee_r}) : rem_sh[12:0];
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) red_r <= sat_red({dq_r[23:0], qbit});
      end
      ST_EXP_IDX: begin
        f_r  <= mul_p[25:10];
        ip_r <= mul_p[33:26];
      end
      ST_EXP_SUM: begin
        if (!ip_r[7]) begin
          gain_r <= 32'(mant) << psh;
        end else if (nsh >= 8'd32) begin
          gain_r <= '0;
        end else begin
          gain_r <= 32'(mant) >> nsh[4:0];
        end
      end
      ST_OUT_B: res_a <= sat16(mul_p);
      ST_OUT_C: res_b <= two_r ? sat16(mul_p) : 16'sd0;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_a        <= res_a;
      out_b        <= res_b;
      reduction_db <= red_r;
    end
  end

endmodule

`default_nettype wire

/* hdl/skac_checker.sv */
`default_nettype none

module skac_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [15:0] out_a,
  input wire logic signed [15:0] out_b,
  input wire logic [14:0]        reduction_db
);

  // a taken word keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again straight after a word");

  a_reduction_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reduction_db <= 15'd24576)
    else $error("reduction above its ceiling");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_a) && $stable(out_b) && $stable(reduction_db))
    else $error("stalled result changed");

endmodule

bind soft_knee_audio_compressor_unit skac_checker u_skac_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_a(out_a),
  .out_b(out_b),
  .reduction_db(reduction_db)
);

`default_nettype wire

/* sim/tb.sv */
`default_nettype none

module tb;
  import skac_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] sample_a = '0;
  logic signed [15:0] sample_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_a;
  logic signed [15:0] out_b;
  logic [14:0] reduction_db;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  soft_knee_audio_compressor_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_a(sample_a), .sample_b(sample_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_a(out_a), .out_b(out_b), .reduction_db(reduction_db),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4000000;
    $display("tb: done, errors");
    $finish;
  end

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic [14:0] red;
  } frame_out_t;

  // predictor state
  logic [23:0] env_q;
  logic en_q;
  logic [1:0] chans_q;
  logic [15:0] att_q, rel_q, slope_q;
  logic signed [15:0] thr_q;
  logic [12:0] knee_q, makeup_q;

  frame_out_t gain_queue[$];
  int n_errors = 0;
  int n_frames = 0;
  int n_words = 0;
  int stall_left = 0;

  // idle-gap draw: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic longint fdiv(longint v, int s);
    return v >>> s;
  endfunction

  function automatic int to_db(logic [23:0] v);
    int p;
    logic [23:0] m;
    int idx, rem;
    longint l, lg;
    p = 23;
    while (p > 0 && !v[p]) p--;
    m = v << (23 - p);
    idx = int'(m[22:19]);
    rem = int'(m[18:11]);
    l = log2_entry(5'(idx)) +
        (((log2_entry(5'(idx + 1)) - log2_entry(5'(idx))) * rem) >> 8);
    lg = longint'(p - 23) * 65536 + l;
    lg = fdiv(lg * 24660 + (1 << 19), 20);
    if (lg < -25600) lg = -25600;
    return int'(lg);
  endfunction

  function automatic longint to_gain(int g);
    longint e, ip, f, m;
    int idx, rem;
    e = fdiv(longint'(g) * 43541, 10);
    ip = fdiv(e, 16);
    f = e - ip * 65536;
    idx = int'(f >> 12);
    rem = int'((f >> 4) & 255);
    m = exp2_entry(5'(idx)) +
        (((exp2_entry(5'(idx + 1)) - exp2_entry(5'(idx))) * rem) >> 8);
    if (ip >= 0) begin
      if (ip > 20) ip = 20;
      return (m << ip) & 64'hFFFF_FFFF;
    end
    if (-ip >= 32) return 0;
    return m >> (-ip);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic frame_out_t compress(logic signed [15:0] a, logic signed [15:0] b);
    frame_out_t r;
    logic two;
    longint lvl, ev, db, over, twice, w, red, q, gain;
    two = (chans_q != 2'd1);
    if (!en_q) begin
      r.a = a; r.b = b; r.red = '0;
      return r;
    end
    lvl = (a < 0) ? -longint'(a) : longint'(a);
    if (two) lvl = (lvl + ((b < 0) ? -longint'(b) : longint'(b))) >> 1;
    lvl = lvl << 8;
    ev = longint'(env_q);
    if (lvl > ev) ev = lvl - ((att_q * (lvl - ev)) >> 16);
    else ev = lvl + ((rel_q * (ev - lvl)) >> 16);
    env_q = ev[23:0];
    db = longint'(to_db(env_q + ENV_EPS));
    over = db - thr_q;
    twice = 2 * over;
    w = longint'(knee_q);
    if (twice <= -w) red = 0;
    else if (twice >= w) red = (over * slope_q) >> 16;
    else begin
      q = twice + w;
      red = (longint'(slope_q) * q * q) / (8 * w * 65536);
    end
    if (red > 24576) red = 24576;
    gain = to_gain(int'(makeup_q) - int'(red));
    r.a = clip16(fdiv(longint'(a) * gain, 16));
    r.b = two ? clip16(fdiv(longint'(b) * gain, 16)) : 16'sd0;
    r.red = red[14:0];
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    paddr <= {idx, 2'b00};
    pwdata <= val;
    pwrite <= 1'b1;
    psel <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ENABLE:    en_q = val[0];
      REG_CHANNELS:  chans_q = val[1:0];
      REG_ATTACK:    att_q = val[15:0];
      REG_RELEASE:   rel_q = val[15:0];
      REG_THRESHOLD: thr_q = val[15:0];
      REG_KNEE:      knee_q = val[12:0];
      REG_SLOPE:     slope_q = val[15:0];
      REG_MAKEUP:    makeup_q = val[12:0];
      default: ;
    endcase
  endtask

  // send one word; a fixed expectation overrides the predictor when given
  task automatic send_frame(logic signed [15:0] a, logic signed [15:0] b,
                            logic fixed, frame_out_t want);
    frame_out_t e;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    sample_a <= a;
    sample_b <= b;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = compress(a, b);
    if (fixed) e = want;
    gain_queue.push_back(e);
    n_words++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (gain_queue.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  // receiver: random stall, check on handshake
  always @(posedge clk) begin
    frame_out_t e;
    if (!rst && out_valid && !out_stall) begin
      if (gain_queue.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected word a=%0d b=%0d red=%0d", out_a, out_b,
                                     reduction_db);
      end else begin
        e = gain_queue.pop_front();
        n_frames++;
        if (e.a !== out_a || e.b !== out_b || e.red !== reduction_db) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: exp a=%0d b=%0d red=%0d got a=%0d b=%0d red=%0d",
                     e.a, e.b, e.red, out_a, out_b, reduction_db);
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= !out_stall;
      stall_left = gap_len();
    end
  end

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic fixed;
    frame_out_t want;
  } stim_row_t;

  stim_row_t rows[$];

  initial begin
    frame_out_t z;
    int k, burst;
    logic signed [15:0] amp;
    z = '0;
    en_q = 1'b1; chans_q = 2'd2; att_q = 16'd65000; rel_q = 16'd65500;
    thr_q = -16'sd5120; knee_q = 13'd1536; slope_q = 16'd49152; makeup_q = '0;
    env_q = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset: silence gives unity gain
    rows.push_back('{16'sd0, 16'sd0, 1'b1, z});
    rows.push_back('{16'sd32767, -16'sd32768, 1'b0, z});
    rows.push_back('{-16'sd32768, 16'sd32767, 1'b0, z});
    rows.push_back('{16'sd1, -16'sd1, 1'b0, z});
    rows.push_back('{16'sd16384, 16'sd16384, 1'b0, z});
    foreach (rows[i]) send_frame(rows[i].a, rows[i].b, rows[i].fixed, rows[i].want);
    drain();

    // pass-through with extremes
    write_reg(REG_ENABLE, 32'd0);
    send_frame(16'sd32767, -16'sd32768, 1'b1, '{16'sd32767, -16'sd32768, 15'd0});
    send_frame(-16'sd32768, 16'sd32767, 1'b1, '{-16'sd32768, 16'sd32767, 15'd0});
    send_frame(16'sh5555, 16'shAAAA, 1'b0, z);
    drain();

    // hard knee, full slope, fast attack, one channel, max makeup
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_CHANNELS, 32'd1);
    write_reg(REG_ATTACK, 32'd0);
    write_reg(REG_RELEASE, 32'd0);
    write_reg(REG_THRESHOLD, 32'hFFFF_A000);
    write_reg(REG_KNEE, 32'd0);
    write_reg(REG_SLOPE, 32'd65535);
    write_reg(REG_MAKEUP, 32'd6144);
    send_frame(16'sd32767, 16'sd123, 1'b0, z);
    send_frame(-16'sd32768, -16'sd5, 1'b0, z);
    send_frame(16'sd0, 16'sd32767, 1'b0, z);
    send_frame(16'sd100, 16'sd0, 1'b0, z);
    drain();

    // widest knee, threshold at 0 dB, slow coefficients, out-of-range channel codes
    write_reg(REG_CHANNELS, 32'd0);
    write_reg(REG_ATTACK, 32'd65535);
    write_reg(REG_RELEASE, 32'd65535);
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_KNEE, 32'd6144);
    write_reg(REG_SLOPE, 32'd0);
    write_reg(REG_MAKEUP, 32'd0);
    send_frame(16'sd32767, 16'sd32767, 1'b0, z);
    send_frame(-16'sd20000, 16'sd20000, 1'b0, z);
    drain();
    write_reg(REG_CHANNELS, 32'd3);
    send_frame(16'sd8000, -16'sd8000, 1'b0, z);
    drain();

    // random phases, each with fresh settings; bursts of loud/quiet passages
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ENABLE, 32'($urandom_range(0, 7) != 0));
      write_reg(REG_CHANNELS, $urandom_range(0, 3));
      write_reg(REG_ATTACK, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                      : $urandom_range(40000, 65535));
      write_reg(REG_RELEASE, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                       : $urandom_range(50000, 65535));
      write_reg(REG_THRESHOLD, 32'(-$signed($urandom_range(0, 24576))));
      write_reg(REG_KNEE, $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6144));
      write_reg(REG_SLOPE, $urandom_range(0, 65535));
      write_reg(REG_MAKEUP, $urandom_range(0, 6144));
      k = 0;
      while (k < 100) begin
        burst = $urandom_range(5, 30);
        amp = $urandom_range(0, 3) == 0 ? 16'sd32767 : 16'($urandom_range(1, 32767));
        for (int j = 0; j < burst && k < 100; j++) begin
          if ($urandom_range(0, 9) == 0)
            send_frame(16'($urandom), 16'($urandom), 1'b0, z);
          else
            send_frame(16'($signed($urandom_range(0, 2 * amp)) - amp),
                       16'($signed($urandom_range(0, 2 * amp)) - amp), 1'b0, z);
          k++;
        end
      end
      drain();
    end

    drain();
    $display("tb: %0d words sent, %0d results checked over directed extremes", n_words,
             n_frames);
    $display("tb: and eight random register settings with loud and quiet bursts");
    if (n_errors == 0 && gain_queue.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* soft_knee_audio_compressor_unit.f */
hdl/skac_pkg.sv
hdl/soft_knee_audio_compressor_unit.sv
hdl/skac_checker.sv
sim/tb.sv
